/* hw/rtl/assert_macros.svh */
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define BBQS_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("assertion failed");

// implication checked in the same cycle
`define BBQS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("implication failed");

// implication whose consequent is checked in the cycle after the antecedent
`define BBQS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define BBQS_ASSERT(label, prop)
`define BBQS_ASSERT_IMPL(label, ante, cons)
`define BBQS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* hw/rtl/bbqs_pkg.sv */
// types, constants and bitrate tables for the quality selector
package bbqs_pkg;

    localparam int          NUM_LEVELS      = 6;
    localparam logic [2:0]  TOP_LEVEL       = 3'd5;
    localparam logic [2:0]  UNSETTLED_COUNT = 3'd3;
    localparam int          CFG_ADDR_W      = 2;
    localparam int          CFG_DATA_W      = 16;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MAX_LEVEL = 2'd0,
        CFG_CRIT_FILL = 2'd1,
        CFG_LOW_FILL  = 2'd2,
        CFG_HIGH_FILL = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]  max_level;
        logic [15:0] crit_fill;
        logic [15:0] low_fill;
        logic [15:0] high_fill;
    } cfg_t;

    typedef struct packed {
        logic [19:0] bandwidth_kbps;
        logic [15:0] fill_level;
        logic [2:0]  play_level;
        logic [2:0]  recent_level_0;
        logic [2:0]  recent_level_1;
        logic [2:0]  recent_level_2;
        logic [2:0]  recent_level_3;
        logic [2:0]  recent_level_4;
        logic        history_full;
    } in_word_t;

    typedef struct packed {
        logic [2:0] chosen_quality;
        logic [2:0] base_quality;
        logic       held_for_stability;
    } out_word_t;

    // level bitrate times 10, compared against 9 * bandwidth
    function automatic logic [23:0] rate_x10(logic [2:0] lvl);
        logic [23:0] r;
        case (lvl)
            3'd0:    r = 24'd4000;
            3'd1:    r = 24'd8000;
            3'd2:    r = 24'd15000;
            3'd3:    r = 24'd30000;
            3'd4:    r = 24'd60000;
            3'd5:    r = 24'd120000;
            default: r = 24'hFFFFFF;
        endcase
        return r;
    endfunction

    // level bitrate times 6, compared against 5 * bandwidth
    function automatic logic [22:0] rate_x6(logic [2:0] lvl);
        logic [22:0] r;
        case (lvl)
            3'd0:    r = 23'd2400;
            3'd1:    r = 23'd4800;
            3'd2:    r = 23'd9000;
            3'd3:    r = 23'd18000;
            3'd4:    r = 23'd36000;
            3'd5:    r = 23'd72000;
            default: r = 23'h7FFFFF;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/bbqs_cfg_regs.sv */
// configuration registers with reset defaults
module bbqs_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [bbqs_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [bbqs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output bbqs_pkg::cfg_t                      cfg
);
    import bbqs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_addr))
                CFG_MAX_LEVEL: cfg_next.max_level = cfg_wdata[2:0];
                CFG_CRIT_FILL: cfg_next.crit_fill = cfg_wdata;
                CFG_LOW_FILL:  cfg_next.low_fill  = cfg_wdata;
                CFG_HIGH_FILL: cfg_next.high_fill = cfg_wdata;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_level <= 3'd5;
            cfg_reg.crit_fill <= 16'd32;
            cfg_reg.low_fill  <= 16'd80;
            cfg_reg.high_fill <= 16'd480;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/bbqs_decide.sv */
// quality decision logic: bandwidth fit, buffer rules, oscillation guard
module bbqs_decide (
    input  bbqs_pkg::in_word_t  in_word,
    input  bbqs_pkg::cfg_t      cfg,
    output bbqs_pkg::out_word_t out_word
);
    import bbqs_pkg::*;

    logic [2:0]            top;
    logic [23:0]           bw_x9;
    logic [22:0]           bw_x5;
    logic [NUM_LEVELS-1:0] fits;
    logic [2:0]            fit;
    logic [2:0]            cur;
    logic [2:0]            target;
    logic [2:0]            base;
    logic [4:0]            diff_vec;
    logic [2:0]            diffs;
    logic                  one_step;
    logic                  hold;

    assign cur   = in_word.play_level;
    assign top   = (cfg.max_level > TOP_LEVEL) ? TOP_LEVEL : cfg.max_level;
    assign bw_x9 = {1'b0, in_word.bandwidth_kbps, 3'b000} + 24'(in_word.bandwidth_kbps);
    assign bw_x5 = {1'b0, in_word.bandwidth_kbps, 2'b00} + 23'(in_word.bandwidth_kbps);

    // per-level fit against 90% of bandwidth
    always_comb begin
        for (int i = 0; i < NUM_LEVELS; i++) begin
            fits[i] = (24'(rate_x10(3'(i))) <= bw_x9);
        end
    end

    // highest fitting level up to the effective maximum
    always_comb begin
        fit = 3'd0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (fits[i] && (3'(i) <= top)) begin
                fit = 3'(i);
            end
        end
    end

    // buffer rules
    always_comb begin
        if (in_word.bandwidth_kbps == 20'd0 || in_word.fill_level < cfg.crit_fill) begin
            target = 3'd0;
        end else if (in_word.fill_level < cfg.low_fill) begin
            target = (cur > 3'd0) ? cur - 3'd1 : 3'd0;
            if (target > fit) target = fit;
        end else if (in_word.fill_level > cfg.high_fill) begin
            target = (cur < top) ? cur + 3'd1 : cur;
            if (target > fit) target = fit;
        end else begin
            if (fit > cur && bw_x5 > rate_x6(cur + 3'd1)) begin
                target = cur + 3'd1;
            end else if (fit < cur) begin
                target = fit;
            end else begin
                target = cur;
            end
        end
    end

    assign base = (target > top) ? top : target;

    // history entries that differ from the current level
    assign diff_vec = {in_word.recent_level_4 != cur, in_word.recent_level_3 != cur,
                       in_word.recent_level_2 != cur, in_word.recent_level_1 != cur,
                       in_word.recent_level_0 != cur};

    always_comb begin
        diffs = 3'd0;
        for (int k = 0; k < 5; k++) begin
            diffs = diffs + 3'(diff_vec[k]);
        end
    end

    // guard against one-step flapping
    assign one_step = ({1'b0, base} == {1'b0, cur} + 4'd1) ||
                      ({1'b0, cur} == {1'b0, base} + 4'd1);
    assign hold     = in_word.history_full && (diffs >= UNSETTLED_COUNT) &&
                      (cur <= TOP_LEVEL) && one_step;

    assign out_word.chosen_quality     = hold ? cur : base;
    assign out_word.base_quality       = base;
    assign out_word.held_for_stability = hold;

endmodule

/* hw/rtl/buffer_based_quality_select.sv */
// top level: input register, decision logic, result register
//
//   channel  | ports                          | word
//   ---------+--------------------------------+------------------------
//   input    | s_valid, s_ready, s_data       | in_word_t, one request
//   result   | m_valid, m_ready, m_data       | out_word_t, one decision
//   config   | cfg_wr_en, cfg_addr, cfg_wdata | 16-bit register write
//
// one word accepted per cycle unless both registers are full and m_ready is low; a word
// taken is held in the input register, then decided and loaded into the result
// register, from which its result is offered on m_data until m_ready takes it
// aresetn is synchronous, active low; it empties both stages and loads the
// register defaults
// a stalled result holds the result register; the input register still takes one
// word if it is empty, and then s_ready stays low until the result moves on
`include "assert_macros.svh"

module buffer_based_quality_select (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  bbqs_pkg::in_word_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output bbqs_pkg::out_word_t              m_data,
    input  logic                             cfg_wr_en,
    input  logic [bbqs_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [bbqs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import bbqs_pkg::*;

    cfg_t      cfg;
    in_word_t  s1_data_reg;
    logic      s1_valid_reg;
    logic      s1_valid_next;
    out_word_t m_data_reg;
    logic      m_valid_reg;
    logic      m_valid_next;
    out_word_t decide_out;
    logic      out_ready;

    // configuration registers
    bbqs_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // decision logic between the two registers
    bbqs_decide u_decide (
        .in_word  (s1_data_reg),
        .cfg      (cfg),
        .out_word (decide_out)
    );

    // stage flow control
    assign out_ready = !m_valid_reg || m_ready;
    assign s_ready   = !s1_valid_reg || out_ready;

    always_comb begin
        s1_valid_next = s_ready ? s_valid : s1_valid_reg;
        m_valid_next  = out_ready ? s1_valid_reg : m_valid_reg;
    end

    // valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_data_reg <= s_data;
        end
        if (out_ready && s1_valid_reg) begin
            m_data_reg <= decide_out;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    `BBQS_ASSERT_IMPL(a_base_clamped, m_valid_reg,
        m_data_reg.base_quality <= cfg.max_level && m_data_reg.base_quality <= TOP_LEVEL)
    `BBQS_ASSERT_IMPL(a_held_differs, m_valid_reg && m_data_reg.held_for_stability,
        m_data_reg.chosen_quality != m_data_reg.base_quality)
    `BBQS_ASSERT_IMPL(a_free_follows, m_valid_reg && !m_data_reg.held_for_stability,
        m_data_reg.chosen_quality == m_data_reg.base_quality)
    `BBQS_ASSERT_NEXT(a_stage_kept, s1_valid_reg && !out_ready, s1_valid_reg)
    `BBQS_ASSERT_NEXT(a_stage_moves, s1_valid_reg && out_ready, m_valid_reg)

endmodule
